FILE: rtl/fslc_pkg.sv
package fslc_pkg;

  // Request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Switch addresses with side effects beyond the latch line
  localparam logic [3:0] OFS_MOTOR_OFF = 4'h8;
  localparam logic [3:0] OFS_MOTOR_ON  = 4'h9;
  localparam logic [3:0] OFS_DRIVE_1   = 4'hA;
  localparam logic [3:0] OFS_DRIVE_2   = 4'hB;

  // Latch line positions
  localparam int LN_PH1   = 1;
  localparam int LN_PH3   = 3;
  localparam int LN_MOTOR = 4;
  localparam int LN_DRIVE = 5;
  localparam int LN_Q6    = 6;
  localparam int LN_Q7    = 7;

  // Q7/Q6 register select
  localparam logic [1:0] QSEL_DATA      = 2'b00;
  localparam logic [1:0] QSEL_STATUS    = 2'b01;
  localparam logic [1:0] QSEL_HANDSHAKE = 2'b10;

  // Enable line codes
  localparam logic [1:0] EN_NONE   = 2'd0;
  localparam logic [1:0] EN_DRIVE1 = 2'd1;
  localparam logic [1:0] EN_DRIVE2 = 2'd2;

  // Read constants
  localparam logic [7:0] RD_FLOAT   = 8'hff;
  localparam logic [7:0] HS_READY   = 8'h80;
  localparam logic [7:0] HS_BUSY    = 8'hc0;
  localparam logic [4:0] MODE_RESET = 5'h1f;
  localparam logic [2:0] HS_LAST    = 3'd3;
  localparam int         MODE_IMMED = 2;

  localparam int         CFG_WIDTH       = 16;
  localparam logic [15:0] DELAY_RESET    = 16'd1000;
  localparam int         DELAY_WIDTH_DEF = 16;

  typedef struct packed {
    logic [7:0] latch;
    logic [4:0] mode;
    logic [2:0] hs_phase;
    logic       off_pending;
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       phase_valid;
    logic [3:0] phase_lines;
    logic       enable_valid;
    logic [1:0] drive_enable;
    logic       drive_read_strobe;
    logic       drive_write_valid;
    logic [7:0] drive_write_byte;
  } result_t;

endpackage

FILE: rtl/fslc_step.sv
module fslc_step import fslc_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic [1:0]             req_type,
  input  logic [3:0]             offset,
  input  logic [7:0]             write_byte,
  input  logic                   drive_sense,
  input  logic [7:0]             drive_byte,
  input  ctl_state_t             st,
  input  logic [DELAY_WIDTH-1:0] countdown,
  input  logic [DELAY_WIDTH-1:0] delay_load,
  output ctl_state_t             st_next,
  output logic [DELAY_WIDTH-1:0] countdown_next,
  output result_t                res
);

  logic [7:0] latch;
  logic       en2;
  logic [2:0] hs_v;

  always_comb begin
    st_next        = st;
    countdown_next = countdown;
    res            = '0;
    latch          = st.latch;
    en2            = 1'b0;
    hs_v           = '0;

    case (req_type) inside
      REQ_TICK: begin
        // delayed motor-off countdown
        if (st.off_pending) begin
          if (countdown <= DELAY_WIDTH'(1)) begin
            st_next.off_pending = 1'b0;
            countdown_next      = '0;
            latch[LN_MOTOR]     = 1'b0;
            res.enable_valid    = 1'b1;
            res.drive_enable    = EN_NONE;
          end else begin
            countdown_next = countdown - DELAY_WIDTH'(1);
          end
        end
      end
      REQ_READ, REQ_WRITE: begin
        // every access sets or clears one latch line
        latch[offset[3:1]] = offset[0];
        res.phase_valid    = ~offset[3];

        unique case (offset)
          OFS_MOTOR_OFF: begin
            if (st.mode[MODE_IMMED]) begin
              st_next.off_pending = 1'b0;
              countdown_next      = '0;
              latch[LN_MOTOR]     = 1'b0;
              res.enable_valid    = 1'b1;
              res.drive_enable    = EN_NONE;
            end else begin
              st_next.off_pending = 1'b1;
              countdown_next      = delay_load;
            end
          end
          OFS_MOTOR_ON: begin
            st_next.off_pending = 1'b0;
            countdown_next      = '0;
            latch[LN_MOTOR]     = 1'b1;
            res.enable_valid    = 1'b1;
            res.drive_enable    = latch[LN_DRIVE] ? EN_DRIVE2 : EN_DRIVE1;
          end
          OFS_DRIVE_1: begin
            if (latch[LN_MOTOR]) begin
              res.enable_valid = 1'b1;
              res.drive_enable = EN_DRIVE1;
            end
          end
          OFS_DRIVE_2: begin
            if (latch[LN_MOTOR]) begin
              res.enable_valid = 1'b1;
              res.drive_enable = EN_DRIVE2;
            end
          end
          default: ;
        endcase

        en2 = latch[LN_PH1] & latch[LN_PH3];

        // even-address reads: data, status or handshake register, or zero with Q7 and Q6 both set
        if (req_type == REQ_READ && !offset[0]) begin
          case ({latch[LN_Q7], latch[LN_Q6]})
            QSEL_DATA: begin
              if (en2 || !latch[LN_MOTOR]) begin
                res.read_byte = RD_FLOAT;
              end else begin
                res.read_byte         = drive_byte;
                res.drive_read_strobe = 1'b1;
              end
            end
            QSEL_STATUS: begin
              res.read_byte = {(en2 | drive_sense), 1'b0, latch[LN_MOTOR], st.mode};
            end
            QSEL_HANDSHAKE: begin
              if (en2) begin
                hs_v             = (st.hs_phase > HS_LAST) ? 3'd0 : st.hs_phase + 3'd1;
                st_next.hs_phase = hs_v;
                res.read_byte    = (hs_v != 3'd0) ? HS_BUSY : HS_READY;
              end else begin
                res.read_byte = HS_READY;
              end
            end
            default: res.read_byte = '0;
          endcase
        end

        // odd-address writes with Q6 and Q7 set: mode load or drive byte
        if (req_type == REQ_WRITE && offset[0] && latch[LN_Q7] && latch[LN_Q6]) begin
          if (!latch[LN_MOTOR]) begin
            st_next.mode = write_byte[4:0];
          end else if (!en2) begin
            res.drive_write_valid = 1'b1;
            res.drive_write_byte  = write_byte;
          end
        end
      end
      default: ;
    endcase

    st_next.latch   = latch;
    res.phase_lines = latch[3:0];
  end

endmodule

FILE: rtl/floppy_switch_latch_controller.sv
// A transfer accepted into the input register passes through the step logic into
// the result register, which drives the outputs; it waits in the input register
// while the result channel stalls. Throughput: one item per cycle unless the
// result channel stalls; the step logic between the two registers is combinational.
// Reset (rst, synchronous): latch lines 0, mode 0x1f, handshake phase 0, no
// pending motor-off, delay register 1000 ticks; both pipeline stages empty.
module floppy_switch_latch_controller import fslc_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic [3:0]           offset,
  input  logic [7:0]           write_byte,
  input  logic                 drive_sense,
  input  logic [7:0]           drive_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           read_byte,
  output logic                 phase_valid,
  output logic [3:0]           phase_lines,
  output logic                 enable_valid,
  output logic [1:0]           drive_enable,
  output logic                 drive_read_strobe,
  output logic                 drive_write_valid,
  output logic [7:0]           drive_write_byte,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  logic [CFG_WIDTH-1:0]   delay_ticks;
  logic [31:0]            delay_ext;
  logic [DELAY_WIDTH-1:0] delay_load;

  ctl_state_t             st, st_next;
  logic [DELAY_WIDTH-1:0] countdown, countdown_next;

  logic       s1_valid;
  logic [1:0] s1_req;
  logic [3:0] s1_offset;
  logic [7:0] s1_wbyte;
  logic       s1_sense;
  logic [7:0] s1_dbyte;

  result_t res, out_res;
  logic    out_free, advance;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_ticks <= cfg_data;
    end
  end

  assign delay_ext  = {{(32 - CFG_WIDTH){1'b0}}, delay_ticks};
  assign delay_load = delay_ext[DELAY_WIDTH-1:0];

  // pipeline flow
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req    <= req_type;
      s1_offset <= offset;
      s1_wbyte  <= write_byte;
      s1_sense  <= drive_sense;
      s1_dbyte  <= drive_byte;
    end
  end

  fslc_step #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_step (
    .req_type       (s1_req),
    .offset         (s1_offset),
    .write_byte     (s1_wbyte),
    .drive_sense    (s1_sense),
    .drive_byte     (s1_dbyte),
    .st             (st),
    .countdown      (countdown),
    .delay_load     (delay_load),
    .st_next        (st_next),
    .countdown_next (countdown_next),
    .res            (res)
  );

  // controller state, updated as an item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.latch       <= '0;
      st.mode        <= MODE_RESET;
      st.hs_phase    <= '0;
      st.off_pending <= 1'b0;
      countdown      <= '0;
    end else if (advance) begin
      st        <= st_next;
      countdown <= countdown_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign read_byte         = out_res.read_byte;
  assign phase_valid       = out_res.phase_valid;
  assign phase_lines       = out_res.phase_lines;
  assign enable_valid      = out_res.enable_valid;
  assign drive_enable      = out_res.drive_enable;
  assign drive_read_strobe = out_res.drive_read_strobe;
  assign drive_write_valid = out_res.drive_write_valid;
  assign drive_write_byte  = out_res.drive_write_byte;

  // checks
  a_idle_countdown: assert property (@(posedge clk) disable iff (rst)
    !st.off_pending |-> countdown == '0)
    else $error("countdown running with no pending motor-off");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while both stages are blocked");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_write_valid) |-> (!drive_read_strobe && read_byte == '0))
    else $error("drive write and read data in one result");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(advance) && !$past(rst)) |-> ($stable(st) && $stable(countdown)))
    else $error("controller state changed without an item");

endmodule
